// File: hw/rtl/lphash_pkg.sv
`timescale 1ns / 1ps
// Package for the linear-probing hash table: sizes, command codes, beat types
// and the command/status structs between controller and datapath.
// No dependencies.
package lphash_pkg;

	localparam int TABLE_ROWS = 1024;
	localparam int KEY_BITS   = 64;
	localparam int ADDR_W     = $clog2(TABLE_ROWS);
	localparam int SLOT_W     = 10;
	localparam int MASK_W     = 10;
	localparam int CMP_W      = 17;
	localparam int CNT_W      = 32;
	localparam int HASH_W     = 32;
	localparam int PADDR_W    = 2;
	localparam int PDATA_W    = 32;

	localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(1023);

	localparam logic [PADDR_W-1:0] REG_TABLE_MASK = PADDR_W'(0);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]    cmd;
		logic [63:0]   key;
		logic [HASH_W-1:0] hash;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              matched;
		logic              inserted;
		logic              full_res;
		logic [CNT_W-1:0]  access_total;
		logic [CNT_W-1:0]  probe_total;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic clr_init;
		logic clr_wr;
		logic rd;
		logic chk;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

endpackage

// File: hw/rtl/lphash_dp.sv
`timescale 1ns / 1ps
// Datapath: item registers, key store memory, probe compare, counters and
// the output register. Depends on lphash_pkg; driven by lphash_ctrl.
module lphash_dp import lphash_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  req_t              req,
	input  logic [MASK_W-1:0] table_mask,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp
);

	logic [KEY_BITS-1:0] mem [TABLE_ROWS];
	logic [KEY_BITS-1:0] rdata_q;

	logic [1:0]          cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [ADDR_W-1:0]   pos_q;
	logic [ADDR_W-1:0]   start_q;
	logic [ADDR_W-1:0]   last_q;
	logic [ADDR_W-1:0]   n_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [CNT_W-1:0]    acc_q;
	logic [CNT_W-1:0]    prb_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                matched_q;
	logic                inserted_q;
	logic                full_q;
	logic                out_valid_q;
	rsp_t                out_q;

	logic [ADDR_W-1:0]   last_d;
	logic [ADDR_W-1:0]   start_d;
	logic [MASK_W-1:0]   masked;
	logic [ADDR_W-1:0]   pos_next;
	logic                empty;
	logic                hit;
	logic                do_insert;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [KEY_BITS-1:0] wdata;

	always_comb begin
		masked = req.hash[MASK_W-1:0] & table_mask;
		if (CMP_W'(table_mask) > CMP_W'(TABLE_ROWS - 1)) begin
			last_d = ADDR_W'(TABLE_ROWS - 1);
		end else begin
			last_d = ADDR_W'(table_mask);
		end
		if (CMP_W'(masked) > CMP_W'(last_d)) begin
			start_d = last_d;
		end else begin
			start_d = ADDR_W'(masked);
		end
	end

	assign pos_next  = (pos_q >= last_q) ? '0 : pos_q + 1'b1;
	assign empty     = (rdata_q[31:0] == 32'd0);
	assign hit       = (rdata_q == key_q);
	assign do_insert = cmd.chk && empty && (cmd_q == CMD_INSERT) && (key_q[31:0] != 32'd0);

	assign stat.done     = empty || hit || (n_q == last_q);
	assign stat.clr_last = (clr_addr_q == ADDR_W'(TABLE_ROWS - 1));
	assign stat.out_free = !out_valid_q || !rsp_stall;

	// single write port: sweep or insert
	always_comb begin
		we    = cmd.clr_wr || do_insert;
		waddr = cmd.clr_wr ? clr_addr_q : pos_q;
		wdata = cmd.clr_wr ? '0 : key_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q      <= req.cmd;
			key_q      <= req.key[KEY_BITS-1:0];
			pos_q      <= start_d;
			start_q    <= start_d;
			last_q     <= last_d;
			n_q        <= '0;
			slot_q     <= '0;
			matched_q  <= 1'b0;
			inserted_q <= 1'b0;
			full_q     <= 1'b0;
		end else if (cmd.chk) begin
			if (empty) begin
				slot_q     <= SLOT_W'(pos_q);
				inserted_q <= do_insert;
			end else if (hit) begin
				slot_q    <= SLOT_W'(pos_q);
				matched_q <= 1'b1;
			end else if (n_q == last_q) begin
				slot_q <= SLOT_W'(start_q);
				full_q <= 1'b1;
			end else begin
				pos_q <= pos_next;
				n_q   <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			prb_q      <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clr_init) begin
				acc_q      <= '0;
				prb_q      <= '0;
				clr_addr_q <= '0;
			end else begin
				if (cmd.accept && (req.cmd == CMD_INSERT || req.cmd == CMD_LOOKUP)) begin
					acc_q <= acc_q + 1'b1;
				end
				if (cmd.chk) begin
					prb_q <= prb_q + 1'b1;
				end
				if (cmd.clr_wr) begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.slot         <= slot_q;
			out_q.matched      <= matched_q;
			out_q.inserted     <= inserted_q;
			out_q.full_res     <= full_q;
			out_q.access_total <= acc_q;
			out_q.probe_total  <= prb_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: hw/rtl/lphash_ctrl.sv
`timescale 1ns / 1ps
// Controller: state machine sequencing accept, probe read/check, clear sweep
// and result hand-off. Depends on lphash_pkg; drives lphash_dp.
module lphash_ctrl import lphash_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_cmd,
	output logic       req_stall,
	output dp_cmd_t    cmd,
	input  dp_stat_t   stat
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_CLEAR = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   clr_item_q;
	logic   clr_item_d;
	logic   take;

	assign take      = (state_q == ST_IDLE) && req_valid;
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d    = state_q;
		clr_item_d = clr_item_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.accept = 1'b1;
					if (req_cmd == CMD_INSERT || req_cmd == CMD_LOOKUP) begin
						state_d = ST_READ;
					end else if (req_cmd == CMD_CLEAR) begin
						cmd.clr_init = 1'b1;
						clr_item_d   = 1'b1;
						state_d      = ST_CLEAR;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.chk = 1'b1;
				state_d = stat.done ? ST_EMIT : ST_READ;
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					clr_item_d = 1'b0;
					state_d    = clr_item_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// reset starts with a clearing sweep of the key store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_item_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_item_q <= clr_item_d;
		end
	end

endmodule

// File: hw/rtl/linear_probe_hash_insert_lookup.sv
`timescale 1ns / 1ps
// Top level of the linear-probing hash table: APB mask register, controller
// and datapath. Depends on lphash_pkg, lphash_ctrl and lphash_dp.
//
// Usage:
//  - req channel (req_valid/req_stall/req): one beat per command; insert,
//    lookup, clear or no-op. A beat is taken when req_valid is high and
//    req_stall is low. One item is worked on at a time.
//  - rsp channel (rsp_valid/rsp_stall/rsp): exactly one beat per item, in
//    order. The result sits in an output register, so a stalled rsp beat
//    does not block the next request unless a further result is ready.
//  - Lookup/insert: each probed slot takes a key store read (ST_READ), then
//    a compare (ST_CHECK). The next item is accepted only once the result
//    of the last one has been emitted into the output register. On a full
//    table every slot up to the last one in use is probed.
//  - Clear: sweeps the 1024-entry key store one row a cycle, then returns
//    its result.
//  - Reset: the same sweep runs with req_stall high; table_mask returns to
//    1023. APB writes are taken at any time, pready tied high.
module linear_probe_hash_insert_lookup import lphash_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [MASK_W-1:0] mask_q;
	dp_cmd_t           dp_cmd;
	dp_stat_t          dp_stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == REG_TABLE_MASK)) begin
			mask_q <= pwdata[MASK_W-1:0];
		end
	end

	assign prdata = PDATA_W'(mask_q) & {PDATA_W{paddr == REG_TABLE_MASK}};

	lphash_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	lphash_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.req        (req),
		.table_mask (mask_q),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

// File: tb/sv/tb_linear_probe_hash_insert_lookup.sv
`timescale 1ns / 1ps
// Testbench for linear_probe_hash_insert_lookup: insert, lookup, clear and no-op beats
// with random idling on both channels; every reply is checked against a shadow table.
// Depends on lphash_pkg and the block's RTL only.
module tb_linear_probe_hash_insert_lookup;
	import lphash_pkg::*;

	localparam logic [1:0]         CMD_NOP        = 2'd3;
	localparam int                 QUIET_LIMIT    = 20000;
	localparam int                 POOL_SIZE      = 32;

	class probe_tracker;
		logic [KEY_BITS-1:0] shadow [TABLE_ROWS];
		logic [CNT_W-1:0]    accesses;
		logic [CNT_W-1:0]    probes;
		logic [MASK_W-1:0]   mask;
		rsp_t                pending_rsp [$];
		int                  errors;
		int                  replies;
		int                  hits;
		int                  inserts;
		int                  fulls;
		int                  clears;

		function new();
			foreach (shadow[i]) shadow[i] = '0;
			accesses = '0;
			probes   = '0;
			mask     = MASK_RESET;
			errors   = 0;
			replies  = 0;
			hits     = 0;
			inserts  = 0;
			fulls    = 0;
			clears   = 0;
		endfunction

		function void take_request(req_t r);
			rsp_t                e;
			logic [KEY_BITS-1:0] k;
			int                  last;
			int                  start;
			int                  pos;
			bit                  found;
			e     = '0;
			found = 1'b0;
			k     = r.key[KEY_BITS-1:0];
			if (r.cmd == CMD_CLEAR) begin
				foreach (shadow[i]) shadow[i] = '0;
				accesses = '0;
				probes   = '0;
				clears++;
			end else if (r.cmd == CMD_INSERT || r.cmd == CMD_LOOKUP) begin
				last  = (int'(mask) > TABLE_ROWS - 1) ? TABLE_ROWS - 1 : int'(mask);
				start = int'(r.hash[MASK_W-1:0] & mask);
				if (start > last)
					start = last;
				accesses += 1;
				pos = start;
				for (int n = 0; n <= last; n++) begin
					probes += 1;
					if (shadow[pos][31:0] == '0) begin
						if (r.cmd == CMD_INSERT && k[31:0] != '0) begin
							shadow[pos] = k;
							e.inserted  = 1'b1;
						end
						found = 1'b1;
						break;
					end
					if (shadow[pos] == k) begin
						e.matched = 1'b1;
						found     = 1'b1;
						break;
					end
					pos = (pos >= last) ? 0 : pos + 1;
				end
				e.slot     = SLOT_W'(found ? pos : start);
				e.full_res = !found;
			end
			e.access_total = accesses;
			e.probe_total  = probes;
			pending_rsp.push_back(e);
		endfunction

		task report(string what);
			errors++;
			$display("ERROR at %0t: %s", $time, what);
		endtask

		task match_reply(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				report($sformatf("reply %h with no request pending", got));
				return;
			end
			e = pending_rsp.pop_front();
			replies++;
			if (e.matched)
				hits++;
			if (e.inserted)
				inserts++;
			if (e.full_res)
				fulls++;
			if (got.slot !== e.slot)
				report($sformatf("reply %0d: slot %0d, want %0d", replies, got.slot, e.slot));
			if (got.matched !== e.matched)
				report($sformatf("reply %0d: matched %b, want %b", replies, got.matched,
					e.matched));
			if (got.inserted !== e.inserted)
				report($sformatf("reply %0d: inserted %b, want %b", replies, got.inserted,
					e.inserted));
			if (got.full_res !== e.full_res)
				report($sformatf("reply %0d: full_res %b, want %b", replies, got.full_res,
					e.full_res));
			if (got.access_total !== e.access_total)
				report($sformatf("reply %0d: access_total %h, want %h", replies,
					got.access_total, e.access_total));
			if (got.probe_total !== e.probe_total)
				report($sformatf("reply %0d: probe_total %h, want %h", replies,
					got.probe_total, e.probe_total));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	req_t               req;
	logic               rsp_valid;
	logic               rsp_stall;
	rsp_t               rsp;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	probe_tracker sb;
	int           src_idle_pct;
	int           sink_idle_pct;
	int           quiet_cycles;
	int           mask_writes;
	logic [63:0]  pool_key  [POOL_SIZE];
	logic [31:0]  pool_hash [POOL_SIZE];

	linear_probe_hash_insert_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.match_reply(rsp);
			if (req_valid && !req_stall)
				sb.take_request(req);
		end
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	function automatic req_t make_beat(logic [1:0] c, logic [63:0] k, logic [31:0] h);
		req_t r;
		r.cmd  = c;
		r.key  = k;
		r.hash = h;
		return r;
	endfunction

	function automatic logic [MASK_W-1:0] plan_mask(int seg);
		case (seg)
			0:       return 10'd1023;
			1:       return 10'd0;
			2:       return 10'd7;
			3:       return 10'd5;
			4:       return 10'd63;
			5:       return 10'd1;
			6:       return 10'd600;
			7:       return 10'd3;
			8:       return 10'd15;
			9:       return 10'd12;
			10:      return 10'd31;
			default: return 10'd1023;
		endcase
	endfunction

	task automatic refresh_pool(int n);
		int idx;
		repeat (n) begin
			idx            = $urandom_range(0, POOL_SIZE - 1);
			pool_key[idx]  = {$urandom(), $urandom()};
			if ($urandom_range(0, 15) == 0)
				pool_key[idx][31:0] = '0;
			pool_hash[idx] = $urandom();
		end
	endtask

	// Mostly keys from a small pool with their own hash, so repeats hit; some noise.
	function automatic req_t random_beat();
		int          roll;
		int          idx;
		logic [1:0]  c;
		logic [63:0] k;
		logic [31:0] h;
		roll = $urandom_range(0, 99);
		if (roll < 47)
			c = CMD_INSERT;
		else if (roll < 93)
			c = CMD_LOOKUP;
		else if (roll < 96)
			c = CMD_NOP;
		else
			c = CMD_CLEAR;
		idx  = $urandom_range(0, POOL_SIZE - 1);
		k    = pool_key[idx];
		h    = pool_hash[idx];
		roll = $urandom_range(0, 99);
		if (roll < 5)
			k = {$urandom(), $urandom()};
		else if (roll < 10)
			h = $urandom();
		return make_beat(c, k, h);
	endfunction

	// Entered and left at a falling edge.
	task automatic send_beat(req_t r);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pending_rsp.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] a,
			input logic [PDATA_W-1:0] d, output logic [PDATA_W-1:0] q);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		q = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_mask(logic [MASK_W-1:0] m);
		logic [PDATA_W-1:0] d;
		logic [PDATA_W-1:0] rd;
		d             = $urandom();
		d[MASK_W-1:0] = m;
		apb_xfer(1'b1, REG_TABLE_MASK, d, rd);
		sb.mask = m;
		mask_writes++;
		apb_xfer(1'b0, REG_TABLE_MASK, $urandom(), rd);
		if (rd[MASK_W-1:0] !== m)
			sb.report($sformatf("table_mask reads %h, want %h", rd[MASK_W-1:0], m));
	endtask

	initial begin
		sb            = new();
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		arst_n        = 1'b0;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		quiet_cycles  = 0;
		mask_writes   = 0;
		foreach (pool_key[i]) pool_key[i] = {$urandom(), $urandom()};
		foreach (pool_hash[i]) pool_hash[i] = $urandom();
		refresh_pool(4 * POOL_SIZE);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// full 1024-slot table: collisions on the low word, wrap from the top slot
		send_beat(make_beat(CMD_INSERT, '1, '1));
		send_beat(make_beat(CMD_LOOKUP, '1, '1));
		send_beat(make_beat(CMD_INSERT, 64'h1, '0));
		send_beat(make_beat(CMD_INSERT, 64'hFFFF_FFFF_0000_0001, '0));
		send_beat(make_beat(CMD_LOOKUP, 64'hFFFF_FFFF_0000_0001, '0));
		send_beat(make_beat(CMD_INSERT, 64'hABCD_1234_0000_0000, 32'd5));
		send_beat(make_beat(CMD_LOOKUP, 64'h8000_0000_0000_0000, '0));
		send_beat(make_beat(CMD_LOOKUP, 64'h2, '1));
		send_beat(make_beat(CMD_NOP, '1, '1));
		send_beat(make_beat(CMD_INSERT, 64'h3, 32'hFFFF_FC00 | 32'd1023));
		send_beat(make_beat(CMD_CLEAR, '1, '1));
		send_beat(make_beat(CMD_LOOKUP, '1, '1));
		settle();

		// single slot: second key finds the table full
		set_mask(10'd0);
		send_beat(make_beat(CMD_INSERT, 64'h5, $urandom()));
		send_beat(make_beat(CMD_INSERT, 64'h6, $urandom()));
		send_beat(make_beat(CMD_LOOKUP, 64'h5, $urandom()));
		send_beat(make_beat(CMD_LOOKUP, 64'h7777_0000_0000_0000, $urandom()));
		settle();

		// mask that is not a power of two minus one
		set_mask(10'd5);
		send_beat(make_beat(CMD_INSERT, 64'h10, '1));
		send_beat(make_beat(CMD_INSERT, 64'h11, '1));
		send_beat(make_beat(CMD_INSERT, 64'h12, 32'd2));
		send_beat(make_beat(CMD_LOOKUP, 64'h11, '1));

		for (int ph = 0; ph < 3; ph++) begin
			settle();
			src_idle_pct  = (ph == 0) ? 25 : (ph == 1) ? 48 : 0;
			sink_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 25 : 0;
			for (int seg = 0; seg < 4; seg++) begin
				settle();
				set_mask(plan_mask(ph * 4 + seg));
				refresh_pool(8);
				repeat (70) send_beat(random_beat());
			end
		end
		settle();
		repeat (20) @(negedge clk);

		if (sb.pending_rsp.size() != 0)
			sb.report($sformatf("%0d replies never came", sb.pending_rsp.size()));
		$display("covered %0d replies: %0d inserts, %0d hits, %0d full-table, %0d clears",
			sb.replies, sb.inserts, sb.hits, sb.fulls, sb.clears);
		$display("table_mask written %0d times (0 to 1023), idling on either side and none",
			mask_writes);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: linear_probe_hash_insert_lookup.f
hw/rtl/lphash_pkg.sv
hw/rtl/lphash_dp.sv
hw/rtl/lphash_ctrl.sv
hw/rtl/linear_probe_hash_insert_lookup.sv
tb/sv/tb_linear_probe_hash_insert_lookup.sv
